FILE: design/wsmb_pkg.sv
// Shared types and constants for the windowed step median bound block.
package wsmb_pkg;

  localparam int STEP_W     = 12;
  localparam int BOUND_W    = 13;
  localparam int MS_W       = 3;
  localparam int MJ_W       = 8;
  localparam int PCT_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_JITTER     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_JITTER_PERCENT = 2'd2;

  localparam logic [MS_W-1:0]  MIN_SAMPLES_RST    = 3'd3;
  localparam logic [MJ_W-1:0]  MIN_JITTER_RST     = 8'd4;
  localparam logic [PCT_W-1:0] JITTER_PERCENT_RST = 7'd5;

  // Ceiling of x/100 is floor((x + 99) * RECIP >> SHIFT); exact for x below 2^20.
  localparam int PROD_W   = STEP_W + PCT_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int RECIP_W  = 20;
  localparam int DIV_SHIFT = 26;
  localparam int FULL_W   = SUM_W + RECIP_W;
  localparam int QUOT_W   = FULL_W - DIV_SHIFT;
  localparam logic [SUM_W-1:0]   ROUND_UP  = 20'd99;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 20'd671089;
  localparam logic [BOUND_W-1:0] BOUND_MAX = 13'd8191;

  typedef struct packed {
    logic              push;
    logic [STEP_W-1:0] step;
  } win_push_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] median;
    logic [STEP_W-1:0] lo;
    logic [STEP_W-1:0] hi;
  } jit_req_t;

  typedef struct packed {
    logic               done;
    logic               ok;
    logic [BOUND_W-1:0] bound;
  } jit_res_t;

endpackage

FILE: design/windowed_step_median_bound_core.sv
// Top level of the windowed step median bound block: sequencer, rank loop and result register.
//
// Each input item carries one step (step_delta_i) on the in_valid_i / in_ready_o channel. A
// nonzero step enters a first-in, first-out window of WINDOW entries, dropping the oldest when
// full; a zero step only queries. Each item gives exactly one result on out_valid_o /
// out_ready_i: bound_valid_o and upper_bound_o (zero when no bound is given).
// The median, minimum and maximum come from a rank loop: for each of the n stored steps one
// comparator counts the entries ranked below it over one read port of the window. A
// three-stage multiply unit then forms the jitter and the bound. When the window is empty or
// holds fewer than min_samples steps, the rank loop and multiply unit are skipped. in_ready_o
// is high only while the sequencer is idle, so one item is in work at a time. The result
// register holds a finished item while the receiver stalls; the next item is accepted
// meanwhile and waits in its final state until the register is free. Reset empties the window
// and loads the register defaults (min_samples 3, min_jitter 4, jitter_percent 5).
// Configuration is to be written only while idle; the block itself does not enforce this.
module windowed_step_median_bound_core import wsmb_pkg::*; #(
  parameter int WINDOW = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [STEP_W-1:0]     step_delta_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  bound_valid_o,
  output logic [BOUND_W-1:0]    upper_bound_o
);

  localparam int IdxW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CntW = $clog2(WINDOW + 1);
  localparam int CmpW = (CntW > MS_W) ? CntW : MS_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CHK  = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_JIT  = 3'd4;
  localparam logic [2:0] ST_WAIT = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [MS_W-1:0]    min_samples_q;
  logic [MJ_W-1:0]    min_jitter_q;
  logic [PCT_W-1:0]   jitter_percent_q;

  logic [IdxW-1:0]    p_q, p_d, j_q, j_d, rank_q, rank_d;
  logic [STEP_W-1:0]  cand_q, cand_d, lo_q, lo_d, hi_q, hi_d, med_q, med_d;
  logic               res_ok_q, res_ok_d;
  logic [BOUND_W-1:0] res_bound_q, res_bound_d;
  logic               out_valid_q, out_valid_d;
  logic               out_ok_q;
  logic [BOUND_W-1:0] out_bound_q;

  win_push_t          push;
  jit_req_t           jreq;
  jit_res_t           jres;
  logic [IdxW-1:0]    rd_idx;
  logic [STEP_W-1:0]  rd_data;
  logic [CntW-1:0]    count, cnt_m1, cnt_half;
  logic [IdxW-1:0]    last_idx, med_idx, rank_fin;
  logic               in_fire, below, slot_free, load_out;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  assign push.push = in_fire && (step_delta_i != '0);
  assign push.step = step_delta_i;

  assign rd_idx = (state_q == ST_LOAD) ? p_q : j_q;

  wsmb_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data),
    .count_o   (count)
  );

  assign jreq.start  = (state_q == ST_JIT);
  assign jreq.median = med_q;
  assign jreq.lo     = lo_q;
  assign jreq.hi     = hi_q;

  wsmb_jitter u_jitter (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (jreq),
    .min_jitter_i     (min_jitter_q),
    .jitter_percent_i (jitter_percent_q),
    .res_o            (jres)
  );

  assign cnt_m1   = count - CntW'(1);
  assign cnt_half = count >> 1;
  assign last_idx = cnt_m1[IdxW-1:0];
  assign med_idx  = cnt_half[IdxW-1:0];

  // Ties are ranked by window position, so the ranks always form a permutation.
  assign below    = (rd_data < cand_q) || ((rd_data == cand_q) && (j_q < p_q));
  assign rank_fin = rank_q + IdxW'(below);

  assign slot_free = !out_valid_q || out_ready_i;
  assign load_out  = (state_q == ST_OUT) && slot_free;

  always_comb begin
    state_d     = state_q;
    p_d         = p_q;
    j_d         = j_q;
    rank_d      = rank_q;
    cand_d      = cand_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    med_d       = med_q;
    res_ok_d    = res_ok_q;
    res_bound_d = res_bound_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if ((count == '0) || (CmpW'(count) < CmpW'(min_samples_q))) begin
          res_ok_d    = 1'b0;
          res_bound_d = '0;
          state_d     = ST_OUT;
        end else begin
          p_d     = '0;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cand_d  = rd_data;
        j_d     = '0;
        rank_d  = '0;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        rank_d = rank_fin;
        if (j_q == last_idx) begin
          if (rank_fin == '0) begin
            lo_d = cand_q;
          end
          if (rank_fin == last_idx) begin
            hi_d = cand_q;
          end
          if (rank_fin == med_idx) begin
            med_d = cand_q;
          end
          if (p_q == last_idx) begin
            state_d = ST_JIT;
          end else begin
            p_d     = p_q + IdxW'(1);
            state_d = ST_LOAD;
          end
        end else begin
          j_d = j_q + IdxW'(1);
        end
      end
      ST_JIT: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (jres.done) begin
          res_ok_d    = jres.ok;
          res_bound_d = jres.bound;
          state_d     = ST_OUT;
        end
      end
      ST_OUT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      out_valid_q      <= 1'b0;
      min_samples_q    <= MIN_SAMPLES_RST;
      min_jitter_q     <= MIN_JITTER_RST;
      jitter_percent_q <= JITTER_PERCENT_RST;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_SAMPLES:    min_samples_q    <= cfg_data_i[MS_W-1:0];
          CFG_MIN_JITTER:     min_jitter_q     <= cfg_data_i[MJ_W-1:0];
          CFG_JITTER_PERCENT: jitter_percent_q <= cfg_data_i[PCT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q         <= p_d;
    j_q         <= j_d;
    rank_q      <= rank_d;
    cand_q      <= cand_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    med_q       <= med_d;
    res_ok_q    <= res_ok_d;
    res_bound_q <= res_bound_d;
    if (load_out) begin
      out_ok_q    <= res_ok_q;
      out_bound_q <= res_bound_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign bound_valid_o = out_ok_q;
  assign upper_bound_o = out_bound_q;

endmodule

FILE: design/wsmb_window.sv
// Step window: first-in, first-out register store with one read port.
module wsmb_window import wsmb_pkg::*; #(
  parameter int WINDOW = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  win_push_t                         push_i,
  input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] rd_idx_i,
  output logic [STEP_W-1:0]                 rd_data_o,
  output logic [$clog2(WINDOW+1)-1:0]       count_o
);

  localparam int IdxW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CntW = $clog2(WINDOW + 1);

  logic [STEP_W-1:0] win_q [WINDOW];
  logic [CntW-1:0]   count_q, count_d;
  logic              full;

  assign full = (count_q == CntW'(WINDOW));

  always_comb begin
    count_d = count_q;
    if (push_i.push && !full) begin
      count_d = count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // When full, every entry moves one place toward the head and the new step enters at the tail.
  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      if (full) begin
        for (int k = 0; k < WINDOW - 1; k++) begin
          win_q[k] <= win_q[k+1];
        end
        win_q[WINDOW-1] <= push_i.step;
      end else begin
        win_q[count_q[IdxW-1:0]] <= push_i.step;
      end
    end
  end

  assign rd_data_o = win_q[rd_idx_i];
  assign count_o   = count_q;

endmodule

FILE: design/wsmb_jitter.sv
// Jitter and bound unit: percent of median, ceiling divide by 100, minimum-jitter floor, spread check, saturation.
module wsmb_jitter import wsmb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  jit_req_t         req_i,
  input  logic [MJ_W-1:0]  min_jitter_i,
  input  logic [PCT_W-1:0] jitter_percent_i,
  output jit_res_t         res_o
);

  logic               v1_q, v2_q, done_q;
  logic [PROD_W-1:0]  prod_q;
  logic [FULL_W-1:0]  full_q;
  logic [STEP_W-1:0]  lo1_q, hi1_q, lo2_q, hi2_q;
  logic               ok_q;
  logic [BOUND_W-1:0] bound_q;

  logic [SUM_W-1:0]   rounded;
  logic [QUOT_W-1:0]  pj, jitter;
  logic [STEP_W-1:0]  spread;
  logic [QUOT_W:0]    sum;
  logic               ok_d;
  logic [BOUND_W-1:0] bound_d;

  assign rounded = SUM_W'(prod_q) + ROUND_UP;
  assign pj      = full_q[FULL_W-1:DIV_SHIFT];

  always_comb begin
    jitter  = (pj > QUOT_W'(min_jitter_i)) ? pj : QUOT_W'(min_jitter_i);
    spread  = hi2_q - lo2_q;
    ok_d    = (QUOT_W'(spread) <= jitter);
    sum     = (QUOT_W + 1)'(hi2_q) + (QUOT_W + 1)'(jitter);
    bound_d = (sum > (QUOT_W + 1)'(BOUND_MAX)) ? BOUND_MAX : sum[BOUND_W-1:0];
    if (!ok_d) begin
      bound_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= req_i.start;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      prod_q <= PROD_W'(req_i.median) * PROD_W'(jitter_percent_i);
      lo1_q  <= req_i.lo;
      hi1_q  <= req_i.hi;
    end
    if (v1_q) begin
      full_q <= FULL_W'(rounded) * FULL_W'(DIV_RECIP);
      lo2_q  <= lo1_q;
      hi2_q  <= hi1_q;
    end
    if (v2_q) begin
      ok_q    <= ok_d;
      bound_q <= bound_d;
    end
  end

  assign res_o.done  = done_q;
  assign res_o.ok    = ok_q;
  assign res_o.bound = bound_q;

endmodule

FILE: design/wsmb_checker.sv
// Port-level checker for the windowed step median bound block, bound to the top level.
module wsmb_checker import wsmb_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               bound_valid_o,
  input logic [BOUND_W-1:0] upper_bound_o
);

  // One item at a time: the block drops ready right after taking an item.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready stayed high after an item was accepted");

  a_zero_when_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bound_valid_o |-> upper_bound_o == '0)
    else $error("upper bound nonzero on an item without a bound");

  // Stored steps are nonzero, so a valid bound is never zero.
  a_bound_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bound_valid_o |-> upper_bound_o != '0)
    else $error("valid bound of zero");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(bound_valid_o) && $stable(upper_bound_o))
    else $error("result item changed while stalled");

endmodule

bind windowed_step_median_bound_core wsmb_checker u_wsmb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .bound_valid_o (bound_valid_o),
  .upper_bound_o (upper_bound_o)
);

FILE: bench/windowed_step_median_bound_core_tb.sv
// Self-checking testbench for windowed_step_median_bound_core with directed and random items.
module windowed_step_median_bound_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wsmb_pkg::*;

  localparam int WINDOW_DEPTH   = 5;
  localparam int IDLE_PCT       = 20;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 88;
  localparam int RANDOM_PHASES  = 6;
  localparam int ROUNDING       = 99;
  localparam int PERCENT_DIV    = 100;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef struct packed {
    logic               valid;
    logic [BOUND_W-1:0] bound;
  } bound_res_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_ready_o;
  logic [STEP_W-1:0]     step_delta_i  = '0;
  logic                  out_valid_o;
  logic                  out_ready_i   = 1'b0;
  logic                  bound_valid_o;
  logic [BOUND_W-1:0]    upper_bound_o;

  // Mirror of the block's step window and registers.
  logic [STEP_W-1:0] step_hist [WINDOW_DEPTH];
  int                hist_cnt       = 0;
  logic [MS_W-1:0]   cur_min_samp   = MIN_SAMPLES_RST;
  logic [MJ_W-1:0]   cur_min_jitter = MIN_JITTER_RST;
  logic [PCT_W-1:0]  cur_percent    = JITTER_PERCENT_RST;

  bound_res_t bound_q [$];
  int         mismatches   = 0;
  int         stall_cycles = 0;
  bit         calm         = 1'b0;

  windowed_step_median_bound_core #(
    .WINDOW(WINDOW_DEPTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .step_delta_i (step_delta_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .bound_valid_o(bound_valid_o),
    .upper_bound_o(upper_bound_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  function automatic void record_step(input logic [STEP_W-1:0] step);
    if (step != '0) begin
      if (hist_cnt >= WINDOW_DEPTH) begin
        for (int i = 1; i < WINDOW_DEPTH; i++) step_hist[i-1] = step_hist[i];
        step_hist[WINDOW_DEPTH-1] = step;
      end else begin
        step_hist[hist_cnt] = step;
        hist_cnt++;
      end
    end
  endfunction

  function automatic bound_res_t predict_bound();
    logic [STEP_W-1:0] sorted [WINDOW_DEPTH];
    logic [STEP_W-1:0] key;
    int unsigned       median, pct_jit, jitter, lo, hi, sum;
    int                j;
    bound_res_t        res;
    res = '0;
    if (hist_cnt == 0 || hist_cnt < cur_min_samp) return res;
    for (int i = 0; i < hist_cnt; i++) sorted[i] = step_hist[i];
    for (int i = 1; i < hist_cnt; i++) begin
      key = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    // With an even count the upper of the two middle entries is the median.
    median  = sorted[hist_cnt/2];
    pct_jit = (median * cur_percent + ROUNDING) / PERCENT_DIV;
    jitter  = (pct_jit > cur_min_jitter) ? pct_jit : cur_min_jitter;
    lo      = sorted[0];
    hi      = sorted[hist_cnt-1];
    if (hi - lo > jitter) return res;
    sum = hi + jitter;
    if (sum > BOUND_MAX) sum = BOUND_MAX;
    res.valid = 1'b1;
    res.bound = sum[BOUND_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    mismatches++;
  endtask

  task automatic send_step(input logic [STEP_W-1:0] step);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    step_delta_i <= step;
    do @(posedge clk_i); while (!in_ready_o);
    record_step(step);
    bound_q.insert(bound_q.size(), predict_bound());
  endtask

  // Holds the sender back until every outstanding item has produced its result.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (bound_q.size() != 0 || !in_ready_o) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_MIN_SAMPLES:    cur_min_samp   = data[MS_W-1:0];
      CFG_MIN_JITTER:     cur_min_jitter = data[MJ_W-1:0];
      CFG_JITTER_PERCENT: cur_percent    = data[PCT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] samples,
                            input logic [CFG_DATA_W-1:0] jit,
                            input logic [CFG_DATA_W-1:0] pct);
    drain_results();
    write_reg(CFG_MIN_SAMPLES, samples);
    write_reg(CFG_MIN_JITTER, jit);
    write_reg(CFG_JITTER_PERCENT, pct);
    cfg_we_i <= 1'b0;
  endtask

  // An empty window gives no bound even when zero samples are required.
  task automatic test_empty_window();
    set_config(8'd0, MIN_JITTER_RST, CFG_DATA_W'(JITTER_PERCENT_RST));
    send_step(12'd0);
    send_step(12'd200);
  endtask

  // Four stored steps: the upper middle entry must be taken as the median.
  task automatic test_even_median();
    set_config(8'd4, MIN_JITTER_RST, CFG_DATA_W'(JITTER_PERCENT_RST));
    send_step(12'd204);
    send_step(12'd198);
    send_step(12'd202);
    send_step(12'd0);
  endtask

  task automatic test_step_extremes();
    set_config(CFG_DATA_W'(MIN_SAMPLES_RST), MIN_JITTER_RST,
               CFG_DATA_W'(JITTER_PERCENT_RST));
    send_step(12'd1);
    send_step(12'd0);
    repeat (5) send_step(12'hFFF);
  endtask

  // Percent above 100 with full-scale steps pushes the bound past its range.
  task automatic test_saturation();
    set_config(8'd1, 8'd255, 8'd127);
    send_step(12'd0);
    send_step(12'd1);
    repeat (4) send_step(12'd1);
    set_config(8'd1, 8'd0, 8'd0);
    send_step(12'd0);
  endtask

  task automatic test_unreachable_min_samples();
    drain_results();
    write_reg(CFG_UNUSED_IDX, 8'hFF);
    write_reg(CFG_MIN_SAMPLES, 8'd7);
    cfg_we_i <= 1'b0;
    send_step(12'd50);
    send_step(12'd0);
    set_config(8'd6, 8'd10, 8'd10);
    send_step(12'd50);
  endtask

  function automatic int pick_base();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return $urandom_range(1, 64);
    if (sel < 5) return $urandom_range(3900, 4095);
    return $urandom_range(1, 4095);
  endfunction

  // Mostly runs of similar steps so the window settles and bounds are given,
  // mixed with queries and out-of-line steps.
  task automatic test_random_traffic();
    int base, spread, val, pick;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      calm = (p == 0);
      case (p)
        0: set_config(CFG_DATA_W'(MIN_SAMPLES_RST), MIN_JITTER_RST,
                      CFG_DATA_W'(JITTER_PERCENT_RST));
        1: set_config(8'd1, 8'd0, 8'd0);
        2: set_config(8'd5, 8'd255, 8'd100);
        3: set_config(8'd2, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 100)));
        default: set_config(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      base = pick_base();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) base = pick_base();
        if (pick < 72) begin
          spread = (pick % 3 == 0) ? base / 12 : $urandom_range(0, 6);
          val = base + $urandom_range(0, 2 * spread) - spread;
          if (val < 1) val = 1;
          if (val > 4095) val = 4095;
        end else if (pick < 82) begin
          val = 0;
        end else begin
          val = $urandom_range(0, 4095);
        end
        send_step(val[STEP_W-1:0]);
        if ($urandom_range(0, 99) < 2) drain_results();
      end
    end
    calm = 1'b0;
  endtask

  always @(posedge clk_i) begin
    bound_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (bound_q.size() == 0) begin
        report_mismatch("result with no item waiting", 0, 1);
      end else begin
        want = bound_q.pop_front();
        if (bound_valid_o !== want.valid)
          report_mismatch("bound_valid", want.valid, bound_valid_o);
        if (upper_bound_o !== want.bound)
          report_mismatch("upper_bound", want.bound, upper_bound_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", stall_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_window();
    test_even_median();
    test_step_extremes();
    test_saturation();
    test_unreachable_min_samples();
    test_random_traffic();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/wsmb_pkg.sv
design/wsmb_window.sv
design/wsmb_jitter.sv
design/windowed_step_median_bound_core.sv
design/wsmb_checker.sv
bench/windowed_step_median_bound_core_tb.sv
